@@ rtl/tea_pkg.sv @@
// Shared types and constants for the TEA block cipher pipeline.
package tea_pkg;

  localparam int unsigned TeaRounds = 32;
  localparam int unsigned WordW     = 32;
  localparam logic [31:0] TeaDelta  = 32'h9e37_79b9;

  // Configuration register indexes
  typedef enum logic [2:0] {
    KeyWord0 = 3'd0,
    KeyWord1 = 3'd1,
    KeyWord2 = 3'd2,
    KeyWord3 = 3'd3
  } cfg_idx_e;

  // One beat moving down the round pipeline
  typedef struct packed {
    logic             valid;
    logic             decrypt;
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
  } tea_beat_t;

  typedef logic [3:0][WordW-1:0] tea_key_t;

endpackage

@@ rtl/tea_round.sv @@
// One registered half-round of TEA: updates one block word from the other.
module tea_round (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           half_i,
  input  logic [tea_pkg::WordW-1:0]      enc_sum_i,
  input  logic [tea_pkg::WordW-1:0]      dec_sum_i,
  input  tea_pkg::tea_key_t              key_i,
  input  tea_pkg::tea_beat_t             beat_i,
  output tea_pkg::tea_beat_t             beat_o
);
  import tea_pkg::*;

  logic             upd_v0;
  logic [WordW-1:0] src, dst, ka, kb, sum, mix, res;
  logic             valid_q;
  logic             decrypt_q;
  logic [WordW-1:0] v0_q, v1_q;

  // Encrypt updates v0 on the first half, decrypt updates v1 first
  always_comb begin
    upd_v0 = (beat_i.decrypt == half_i);
    src    = upd_v0 ? beat_i.v1 : beat_i.v0;
    dst    = upd_v0 ? beat_i.v0 : beat_i.v1;
    ka     = upd_v0 ? key_i[0] : key_i[2];
    kb     = upd_v0 ? key_i[1] : key_i[3];
    sum    = beat_i.decrypt ? dec_sum_i : enc_sum_i;
    mix    = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    res    = beat_i.decrypt ? (dst - mix) : (dst + mix);
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    decrypt_q <= beat_i.decrypt;
    v0_q      <= upd_v0 ? res : beat_i.v0;
    v1_q      <= upd_v0 ? beat_i.v1 : res;
  end

  assign beat_o = '{valid: valid_q, decrypt: decrypt_q, v0: v0_q, v1: v1_q};

endmodule

@@ rtl/tea_block_cipher.sv @@
// Top level of the pipelined TEA block cipher.
//
// The block takes one 64-bit block per clock cycle, every cycle: busy_o stays
// low, and a block is accepted whenever start_i is high. Each block runs
// through 2*ROUNDS register stages, one half-round (one word update) per
// stage, so its result appears on out_first_o/out_second_o with done_o high
// for exactly one cycle once it has left the last stage. Results leave in
// order and cannot be held off.
// The key is read from the key registers by every stage, so it must only be
// written while no block is in flight.
module tea_block_cipher #(
  parameter int unsigned ROUNDS = tea_pkg::TeaRounds
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [tea_pkg::WordW-1:0]  cfg_data_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       action_i,
  input  logic [tea_pkg::WordW-1:0]  block_first_i,
  input  logic [tea_pkg::WordW-1:0]  block_second_i,
  output logic                       done_o,
  output logic [tea_pkg::WordW-1:0]  out_first_o,
  output logic [tea_pkg::WordW-1:0]  out_second_o
);
  import tea_pkg::*;

  localparam int unsigned Stages = 2 * ROUNDS;

  tea_key_t  key_q, key_d;
  tea_beat_t beat [Stages+1];

  // Key registers
  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        KeyWord0: key_d[0] = cfg_data_i;
        KeyWord1: key_d[1] = cfg_data_i;
        KeyWord2: key_d[2] = cfg_data_i;
        KeyWord3: key_d[3] = cfg_data_i;
        default:  key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // Pipeline never stalls
  assign busy_o = 1'b0;

  assign beat[0] = '{valid:   start_i && !busy_o,
                     decrypt: action_i,
                     v0:      block_first_i,
                     v1:      block_second_i};

  // Round stages: stage g is half g%2 of round g/2
  for (genvar g = 0; g < Stages; g++) begin : g_stage
    localparam logic [WordW-1:0] EncSum =
      WordW'(64'(TeaDelta) * 64'(g / 2 + 1));
    localparam logic [WordW-1:0] DecSum =
      WordW'(64'(TeaDelta) * 64'(ROUNDS - g / 2));
    localparam logic Half = 1'(g % 2);

    tea_round u_round (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .half_i    (Half),
      .enc_sum_i (EncSum),
      .dec_sum_i (DecSum),
      .key_i     (key_q),
      .beat_i    (beat[g]),
      .beat_o    (beat[g+1])
    );
  end

  assign done_o       = beat[Stages].valid;
  assign out_first_o  = beat[Stages].v0;
  assign out_second_o = beat[Stages].v1;

`ifndef SYNTHESIS
  // A result comes out once its block has passed through all Stages registers
  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(Stages) done_o)
    else $error("accepted block produced no result on time");

  a_done_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, Stages))
    else $error("result without an accepted block");
`endif

endmodule

@@ bench/tb_tea_block_cipher.sv @@
// Self-checking testbench for the pipelined TEA block cipher.
module tb_tea_block_cipher;
  import tea_pkg::*;

  localparam int unsigned NumKeyWords = 4;
  localparam int unsigned PipeDepth   = 2 * TeaRounds;
  localparam logic        ActEncrypt  = 1'b0;
  localparam logic        ActDecrypt  = 1'b1;

  typedef struct packed {
    logic [WordW-1:0] first;
    logic [WordW-1:0] second;
  } word_pair_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = '0;
  logic [WordW-1:0] cfg_data_i = '0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic             action_i = 1'b0;
  logic [WordW-1:0] block_first_i = '0;
  logic [WordW-1:0] block_second_i = '0;
  logic             done_o;
  logic [WordW-1:0] out_first_o;
  logic [WordW-1:0] out_second_o;

  // Key as the cipher should currently hold it
  tea_key_t   key_words;
  // Ciphertext/plaintext pairs expected from the pipeline, oldest first
  word_pair_t pending_blocks[$];
  int unsigned err_count = 0;
  bit         gaps_on = 1'b1;

  tea_block_cipher i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .action_i       (action_i),
    .block_first_i  (block_first_i),
    .block_second_i (block_second_i),
    .done_o         (done_o),
    .out_first_o    (out_first_o),
    .out_second_o   (out_second_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit, well above the slowest legal run
  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

  // One half of a TEA round: the word mixed into the other word
  function automatic logic [WordW-1:0] half_round_mix(logic [WordW-1:0] w,
                                                      logic [WordW-1:0] sum,
                                                      logic [WordW-1:0] ka,
                                                      logic [WordW-1:0] kb);
    return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
  endfunction

  // Full TEA encrypt or decrypt of one block under the given key
  function automatic word_pair_t tea_transform(logic decrypt, logic [WordW-1:0] v0_in,
                                               logic [WordW-1:0] v1_in, tea_key_t k);
    logic [WordW-1:0] v0;
    logic [WordW-1:0] v1;
    logic [WordW-1:0] sum;
    word_pair_t       res;
    v0 = v0_in;
    v1 = v1_in;
    if (decrypt == ActEncrypt) begin
      sum = '0;
      for (int r = 0; r < TeaRounds; r++) begin
        sum = sum + TeaDelta;
        v0  = v0 + half_round_mix(v1, sum, k[0], k[1]);
        v1  = v1 + half_round_mix(v0, sum, k[2], k[3]);
      end
    end else begin
      sum = TeaDelta * TeaRounds;
      for (int r = 0; r < TeaRounds; r++) begin
        v1  = v1 - half_round_mix(v0, sum, k[2], k[3]);
        v0  = v0 - half_round_mix(v1, sum, k[0], k[1]);
        sum = sum - TeaDelta;
      end
    end
    res.first  = v0;
    res.second = v1;
    return res;
  endfunction

  // Mostly random words, with the extremes mixed in
  function automatic logic [WordW-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [WordW-1:0] exp_val,
                                 logic [WordW-1:0] got_val);
    err_count++;
    $display("%0t mismatch on %s: expected %08h, got %08h", $time, what, exp_val, got_val);
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    word_pair_t exp_pair;
    if (rst_ni && done_o) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch("unexpected result beat, out_first", '0, out_first_o);
      end else begin
        exp_pair = pending_blocks.pop_front();
        if (out_first_o !== exp_pair.first)
          report_mismatch("out_first", exp_pair.first, out_first_o);
        if (out_second_o !== exp_pair.second)
          report_mismatch("out_second", exp_pair.second, out_second_o);
      end
    end
  end

  // Register write; the caller drops the write enable when done
  task automatic write_reg(logic [2:0] idx, logic [WordW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx < NumKeyWords) key_words[idx[1:0]] = data;
  endtask

  task automatic load_key(tea_key_t k);
    write_reg(KeyWord0, k[0]);
    write_reg(KeyWord1, k[1]);
    write_reg(KeyWord2, k[2]);
    write_reg(KeyWord3, k[3]);
    cfg_we_i <= 1'b0;
  endtask

  // Send one block, with an optional idle burst first; returns the prediction
  task automatic send_block(logic act, logic [WordW-1:0] v0, logic [WordW-1:0] v1,
                            output word_pair_t exp_pair);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i        <= 1'b0;
      action_i       <= 1'($urandom_range(0, 1));
      block_first_i  <= $urandom();
      block_second_i <= $urandom();
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    action_i       <= act;
    block_first_i  <= v0;
    block_second_i <= v1;
    do @(posedge clk_i); while (busy_o);
    exp_pair = tea_transform(act, v0, v1, key_words);
    pending_blocks.push_back(exp_pair);
  endtask

  // Stop sending and wait until the pipeline has returned every block
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
  endtask

  // Zero key straight out of reset, field extremes, both modes
  task automatic test_reset_key();
    word_pair_t p;
    send_block(ActEncrypt, '0, '0, p);
    send_block(ActDecrypt, '0, '0, p);
    send_block(ActEncrypt, '1, '1, p);
    send_block(ActDecrypt, '1, '1, p);
    send_block(ActEncrypt, 32'haaaa_aaaa, 32'h5555_5555, p);
    send_block(ActDecrypt, p.first, p.second, p);
    wait_idle();
  endtask

  // Extreme keys, back-to-back roundtrips and writes to unused indexes
  task automatic test_extreme_keys();
    word_pair_t p;
    load_key({4{32'hffff_ffff}});
    send_block(ActEncrypt, '0, '1, p);
    send_block(ActDecrypt, p.first, p.second, p);
    send_block(ActEncrypt, '1, '0, p);
    send_block(ActDecrypt, '1, '0, p);
    wait_idle();
    load_key({32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'h8000_0000});
    // Writes beyond the key registers must leave the key alone
    for (int i = NumKeyWords; i < (1 << $bits(cfg_idx_i)); i++)
      write_reg(i[2:0], $urandom());
    cfg_we_i <= 1'b0;
    send_block(ActEncrypt, 32'h0123_4567, 32'h89ab_cdef, p);
    send_block(ActDecrypt, p.first, p.second, p);
    send_block(ActEncrypt, 32'h8000_0000, 32'h0000_0001, p);
    send_block(ActDecrypt, 32'h7fff_ffff, 32'hffff_fffe, p);
    wait_idle();
  endtask

  // Random blocks under one key; a share are decrypts of earlier ciphertext
  task automatic test_random_phase(tea_key_t k, int unsigned n_blocks, bit with_gaps);
    word_pair_t p;
    word_pair_t last_cipher;
    logic       act;
    gaps_on = with_gaps;
    load_key(k);
    last_cipher = '0;
    for (int i = 0; i < n_blocks; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_block(ActDecrypt, last_cipher.first, last_cipher.second, p);
      end else begin
        act = 1'($urandom_range(0, 1));
        send_block(act, random_word(), random_word(), p);
        if (act == ActEncrypt) last_cipher = p;
      end
    end
    wait_idle();
  endtask

  initial begin
    key_words = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_extreme_keys();
    test_random_phase({4{32'hffff_ffff}}, 75, 1'b1);
    test_random_phase({$urandom(), $urandom(), $urandom(), $urandom()}, 75, 1'b1);
    test_random_phase({$urandom(), $urandom(), $urandom(), $urandom()}, 75, 1'b0);
    test_random_phase({32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff}, 75, 1'b1);
    test_random_phase({$urandom(), $urandom(), $urandom(), $urandom()}, 75, 1'b1);
    // Last stretch at full rate
    test_random_phase({$urandom(), $urandom(), $urandom(), $urandom()}, 75, 1'b0);

    // Let any stray beat show up before closing
    repeat (PipeDepth + 16) @(posedge clk_i);
    if (pending_blocks.size() != 0)
      report_mismatch("missing result beats, count", '0, pending_blocks.size());
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
